/* rtl/core/ipfix_message_deframer_top_macros.svh */
// Assertion macros for the IPFIX message deframer.
`ifndef IPFIX_MESSAGE_DEFRAMER_TOP_MACROS_SVH
`define IPFIX_MESSAGE_DEFRAMER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Consequent must hold in the cycle after the antecedent.
`define IMD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

/* rtl/core/imd_pkg.sv */
// Types, codes and constants shared by the IPFIX message deframer files.
package imd_pkg;

   localparam int unsigned REG_WIDTH       = 16;
   localparam int unsigned REG_INDEX_WIDTH = 2;
   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned LEN_WIDTH       = 16;
   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned HEADER_BYTES    = 16;
   localparam int unsigned HDR_CNT_WIDTH   = $clog2(HEADER_BYTES);
   localparam int unsigned SET_HDR_BYTES   = 4;
   localparam int unsigned SET_CNT_WIDTH   = $clog2(SET_HDR_BYTES);

   localparam logic [REG_WIDTH-1:0] EXPECTED_VERSION_RESET = 16'd10;
   localparam logic [REG_WIDTH-1:0] TEMPLATE_CODE_RESET    = 16'd2;
   localparam logic [REG_WIDTH-1:0] OPTIONS_CODE_RESET     = 16'd3;

   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      REG_EXPECTED_VERSION = 2'd0,
      REG_TEMPLATE_CODE    = 2'd1,
      REG_OPTIONS_CODE     = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SETHDR = 3'd1,
      PH_BODY   = 3'd2,
      PH_SKIP   = 3'd3,
      PH_HALT   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_MSG    = 3'd0,
      EV_SETHDR = 3'd1,
      EV_BYTE   = 3'd2,
      EV_SKIP   = 3'd3,
      EV_END    = 3'd4,
      EV_ERR    = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      CLASS_TEMPLATE = 2'd0,
      CLASS_OPTIONS  = 2'd1,
      CLASS_DATA     = 2'd2
   } set_class_type;

   typedef enum logic [2:0] {
      ERR_SHORT_HEADER = 3'd0,
      ERR_BAD_VERSION  = 3'd1,
      ERR_SHORT_BODY   = 3'd2,
      ERR_LONG_SET     = 3'd3,
      ERR_BAD_LENGTH   = 3'd4
   } error_type;

   typedef struct packed {
      event_type                 event_res;
      logic                      last_in_set;
      logic                      last_in_message;
      logic [BYTE_WIDTH-1:0]     body_byte;
      logic [REG_WIDTH-1:0]      set_identifier;
      set_class_type             set_class;
      logic [LEN_WIDTH-1:0]      length_field;
      logic [WORD_WIDTH-1:0]     export_time;
      logic [WORD_WIDTH-1:0]     sequence_number;
      logic [WORD_WIDTH-1:0]     domain_id;
      error_type                 error_code;
   } rsp_payload_type;

endpackage

/* rtl/core/imd_channels.sv */
// Valid/ready channel interfaces for the deframer's byte input and event output.
interface imd_req_if import imd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] data_byte;
   logic                  stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface imd_rsp_if import imd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   event_type             event_res;
   logic                  last_in_set;
   logic                  last_in_message;
   logic [BYTE_WIDTH-1:0] body_byte;
   logic [REG_WIDTH-1:0]  set_identifier;
   set_class_type         set_class;
   logic [LEN_WIDTH-1:0]  length_field;
   logic [WORD_WIDTH-1:0] export_time;
   logic [WORD_WIDTH-1:0] sequence_number;
   logic [WORD_WIDTH-1:0] domain_id;
   error_type             error_code;

   modport source (output valid, output event_res, output last_in_set,
                   output last_in_message, output body_byte, output set_identifier,
                   output set_class, output length_field, output export_time,
                   output sequence_number, output domain_id, output error_code,
                   input ready);
   modport sink   (input valid, input event_res, input last_in_set,
                   input last_in_message, input body_byte, input set_identifier,
                   input set_class, input length_field, input export_time,
                   input sequence_number, input domain_id, input error_code,
                   output ready);
endinterface

/* rtl/core/ipfix_message_deframer_top.sv */
// The event for a byte is registered and is on the result channel in the cycle after the byte transfer.
// Throughput: one byte per cycle; the result register takes a new event while
// the previous one is being transferred, so the input stalls only on output backpressure.
// Header and set-header bytes give no event until their last byte arrives.
// Reset is synchronous, active high: clears the phase, counters, halt and result valid,
// and restores the registers to version 10, template code 2, options code 3.
`include "ipfix_message_deframer_top_macros.svh"

module ipfix_message_deframer_top import imd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   imd_req_if.sink                    req_chan,
   imd_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [REG_INDEX_WIDTH-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]       csr_write_data
);

   logic [REG_WIDTH-1:0]            version_ff, template_ff, options_ff;
   phase_type                       phase_ff, phase_in;
   logic [HDR_CNT_WIDTH-1:0]        hdr_cnt_ff, hdr_cnt_in;
   logic [HEADER_BYTES*8-9:0]       hdr_shift_ff, hdr_shift_in;
   logic [LEN_WIDTH-1:0]            msg_rem_ff, msg_rem_in;
   logic [SET_CNT_WIDTH-1:0]        set_cnt_ff, set_cnt_in;
   logic [SET_HDR_BYTES*8-9:0]      set_shift_ff, set_shift_in;
   logic [REG_WIDTH-1:0]            set_id_ff, set_id_in;
   logic [LEN_WIDTH-1:0]            set_rem_ff, set_rem_in;
   set_class_type                   class_ff, class_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type                 rsp_ff, rsp_in;

   logic                            req_fire;
   logic                            has_result;
   rsp_payload_type                 result;
   logic [HEADER_BYTES*8-1:0]       hdr_word;
   logic [SET_HDR_BYTES*8-1:0]      set_word;
   logic [REG_WIDTH-1:0]            hdr_version;
   logic [LEN_WIDTH-1:0]            hdr_length;
   logic [LEN_WIDTH-1:0]            hdr_rem;
   logic [REG_WIDTH-1:0]            set_hdr_id;
   logic [LEN_WIDTH-1:0]            set_hdr_len;
   logic [LEN_WIDTH-1:0]            set_body;
   set_class_type                   set_hdr_class;
   logic [LEN_WIDTH-1:0]            msg_rem_dec;
   logic [LEN_WIDTH-1:0]            set_rem_dec;
   logic                            hdr_done, set_hdr_done;
   logic                            hdr_bad_version, hdr_bad_length;
   logic                            set_bad_length, set_too_long;

   function automatic phase_type advance_phase(input logic [LEN_WIDTH-1:0] rem);
      phase_type ph;
      if (rem == '0) begin
         ph = PH_HEADER;
      end else if (rem >= LEN_WIDTH'(SET_HDR_BYTES)) begin
         ph = PH_SETHDR;
      end else begin
         ph = PH_SKIP;
      end
      return ph;
   endfunction

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign hdr_word        = {hdr_shift_ff, req_chan.data_byte};
   assign set_word        = {set_shift_ff, req_chan.data_byte};
   assign hdr_version     = hdr_word[127:112];
   assign hdr_length      = hdr_word[111:96];
   assign hdr_rem         = hdr_length - LEN_WIDTH'(HEADER_BYTES);
   assign set_hdr_id      = set_word[31:16];
   assign set_hdr_len     = set_word[15:0];
   assign set_body        = set_hdr_len - LEN_WIDTH'(SET_HDR_BYTES);
   assign msg_rem_dec     = msg_rem_ff - 1'b1;
   assign set_rem_dec     = set_rem_ff - 1'b1;
   assign hdr_done        = hdr_cnt_ff == HDR_CNT_WIDTH'(HEADER_BYTES - 1);
   assign set_hdr_done    = set_cnt_ff == SET_CNT_WIDTH'(SET_HDR_BYTES - 1);
   assign hdr_bad_version = hdr_version != version_ff;
   assign hdr_bad_length  = hdr_length < LEN_WIDTH'(HEADER_BYTES);
   assign set_bad_length  = set_hdr_len < LEN_WIDTH'(SET_HDR_BYTES);
   assign set_too_long    = set_body > msg_rem_dec;

   always_comb begin
      if (set_hdr_id == template_ff) begin
         set_hdr_class = CLASS_TEMPLATE;
      end else if (set_hdr_id == options_ff) begin
         set_hdr_class = CLASS_OPTIONS;
      end else begin
         set_hdr_class = CLASS_DATA;
      end
   end

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      hdr_shift_in = hdr_shift_ff;
      msg_rem_in   = msg_rem_ff;
      set_cnt_in   = set_cnt_ff;
      set_shift_in = set_shift_ff;
      set_id_in    = set_id_ff;
      set_rem_in   = set_rem_ff;
      class_in     = class_ff;
      if (req_fire && phase_ff != PH_HALT) begin
         if (req_chan.stream_end) begin
            phase_in = PH_HALT;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  hdr_shift_in = hdr_word[HEADER_BYTES*8-9:0];
                  hdr_cnt_in   = hdr_cnt_ff + 1'b1;
                  if (hdr_done) begin
                     if (hdr_bad_version || hdr_bad_length) begin
                        phase_in = PH_HALT;
                     end else begin
                        msg_rem_in = hdr_rem;
                        phase_in   = advance_phase(hdr_rem);
                        set_cnt_in = '0;
                     end
                  end
               end
               PH_SETHDR: begin
                  set_shift_in = set_word[SET_HDR_BYTES*8-9:0];
                  set_cnt_in   = set_cnt_ff + 1'b1;
                  msg_rem_in   = msg_rem_dec;
                  if (set_hdr_done) begin
                     if (set_bad_length || set_too_long) begin
                        phase_in = PH_HALT;
                     end else begin
                        set_id_in  = set_hdr_id;
                        class_in   = set_hdr_class;
                        set_rem_in = set_body;
                        if (set_body == '0) begin
                           phase_in = advance_phase(msg_rem_dec);
                        end else begin
                           phase_in = PH_BODY;
                        end
                     end
                  end
               end
               PH_BODY: begin
                  set_rem_in = set_rem_dec;
                  msg_rem_in = msg_rem_dec;
                  if (set_rem_dec == '0) begin
                     phase_in = advance_phase(msg_rem_dec);
                  end
               end
               PH_SKIP: begin
                  msg_rem_in = msg_rem_dec;
                  if (msg_rem_dec == '0) begin
                     phase_in = PH_HEADER;
                  end
               end
               default: begin
                  phase_in = PH_HALT;
               end
            endcase
         end
      end
   end

   // Event for the current byte
   always_comb begin
      result     = '0;
      has_result = 1'b0;
      if (phase_ff != PH_HALT) begin
         if (req_chan.stream_end) begin
            has_result = 1'b1;
            if (phase_ff == PH_HEADER && hdr_cnt_ff == '0) begin
               result.event_res = EV_END;
            end else begin
               result.event_res  = EV_ERR;
               result.error_code = (phase_ff == PH_HEADER) ? ERR_SHORT_HEADER
                                                           : ERR_SHORT_BODY;
            end
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (hdr_done) begin
                     has_result = 1'b1;
                     if (hdr_bad_version) begin
                        result.event_res  = EV_ERR;
                        result.error_code = ERR_BAD_VERSION;
                     end else if (hdr_bad_length) begin
                        result.event_res  = EV_ERR;
                        result.error_code = ERR_BAD_LENGTH;
                     end else begin
                        result.event_res       = EV_MSG;
                        result.length_field    = hdr_length;
                        result.export_time     = hdr_word[95:64];
                        result.sequence_number = hdr_word[63:32];
                        result.domain_id       = hdr_word[31:0];
                        result.last_in_message = hdr_rem == '0;
                     end
                  end
               end
               PH_SETHDR: begin
                  if (set_hdr_done) begin
                     has_result = 1'b1;
                     if (set_bad_length) begin
                        result.event_res  = EV_ERR;
                        result.error_code = ERR_BAD_LENGTH;
                     end else if (set_too_long) begin
                        result.event_res  = EV_ERR;
                        result.error_code = ERR_LONG_SET;
                     end else begin
                        result.event_res       = EV_SETHDR;
                        result.set_identifier  = set_hdr_id;
                        result.set_class       = set_hdr_class;
                        result.length_field    = set_body;
                        result.last_in_set     = set_body == '0;
                        result.last_in_message = (set_body == '0) && (msg_rem_dec == '0);
                     end
                  end
               end
               PH_BODY: begin
                  has_result             = 1'b1;
                  result.event_res       = EV_BYTE;
                  result.body_byte       = req_chan.data_byte;
                  result.set_identifier  = set_id_ff;
                  result.set_class       = class_ff;
                  result.last_in_set     = set_rem_dec == '0;
                  result.last_in_message = (set_rem_dec == '0) && (msg_rem_dec == '0);
               end
               PH_SKIP: begin
                  has_result             = 1'b1;
                  result.event_res       = EV_SKIP;
                  result.body_byte       = req_chan.data_byte;
                  result.last_in_message = msg_rem_dec == '0;
               end
               default: begin
                  has_result = 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_fire) begin
         rsp_valid_in = has_result;
         rsp_in       = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff   <= EXPECTED_VERSION_RESET;
         template_ff  <= TEMPLATE_CODE_RESET;
         options_ff   <= OPTIONS_CODE_RESET;
         phase_ff     <= PH_HEADER;
         hdr_cnt_ff   <= '0;
         msg_rem_ff   <= '0;
         set_cnt_ff   <= '0;
         set_rem_ff   <= '0;
         class_ff     <= CLASS_DATA;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (reg_index_type'(csr_index))
               REG_EXPECTED_VERSION: version_ff  <= csr_write_data;
               REG_TEMPLATE_CODE:    template_ff <= csr_write_data;
               REG_OPTIONS_CODE:     options_ff  <= csr_write_data;
               default:              version_ff  <= version_ff;
            endcase
         end
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         msg_rem_ff   <= msg_rem_in;
         set_cnt_ff   <= set_cnt_in;
         set_rem_ff   <= set_rem_in;
         class_ff     <= class_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_shift_ff <= hdr_shift_in;
      set_shift_ff <= set_shift_in;
      set_id_ff    <= set_id_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.event_res       = rsp_ff.event_res;
   assign rsp_chan.last_in_set     = rsp_ff.last_in_set;
   assign rsp_chan.last_in_message = rsp_ff.last_in_message;
   assign rsp_chan.body_byte       = rsp_ff.body_byte;
   assign rsp_chan.set_identifier  = rsp_ff.set_identifier;
   assign rsp_chan.set_class       = rsp_ff.set_class;
   assign rsp_chan.length_field    = rsp_ff.length_field;
   assign rsp_chan.export_time     = rsp_ff.export_time;
   assign rsp_chan.sequence_number = rsp_ff.sequence_number;
   assign rsp_chan.domain_id       = rsp_ff.domain_id;
   assign rsp_chan.error_code      = rsp_ff.error_code;

   `IMD_ASSERT_NEXT(a_halt_sticks, phase_ff == PH_HALT, phase_ff == PH_HALT && !(req_fire && has_result))
   `IMD_ASSERT_NEXT(a_event_registered, req_fire && has_result, rsp_valid_ff)
   `IMD_ASSERT_NOW(a_hdr_count_phase, hdr_cnt_ff != '0, phase_ff == PH_HEADER || phase_ff == PH_HALT)
   `IMD_ASSERT_NOW(a_skip_residue, phase_ff == PH_SKIP, msg_rem_ff != '0 && msg_rem_ff < 16'd4)
   `IMD_ASSERT_NOW(a_set_within_msg, phase_ff == PH_BODY, set_rem_ff != '0 && set_rem_ff <= msg_rem_ff)

endmodule

/* bench/imd_bench_pkg.sv */
// Scoreboard for the IPFIX message deframer bench: event prediction and event checking.
package imd_bench_pkg;
   import imd_pkg::*;

   class deframer_scoreboard;
      logic [REG_WIDTH-1:0]  version_code;
      logic [REG_WIDTH-1:0]  template_code;
      logic [REG_WIDTH-1:0]  options_code;

      phase_type             phase;
      int unsigned           hdr_count;
      logic [127:0]          hdr_bytes;
      logic [LEN_WIDTH-1:0]  msg_left;
      int unsigned           sethdr_count;
      logic [31:0]           sethdr_bytes;
      logic [LEN_WIDTH-1:0]  set_left;
      set_class_type         cur_class;
      bit                    halted;

      rsp_payload_type       pending_events[$];
      int unsigned           mismatches;
      int unsigned           events_seen;
      int unsigned           max_reports;

      function new();
         version_code  = EXPECTED_VERSION_RESET;
         template_code = TEMPLATE_CODE_RESET;
         options_code  = OPTIONS_CODE_RESET;
         phase         = PH_HEADER;
         hdr_count     = 0;
         hdr_bytes     = '0;
         msg_left      = '0;
         sethdr_count  = 0;
         sethdr_bytes  = '0;
         set_left      = '0;
         cur_class     = CLASS_DATA;
         halted        = 1'b0;
         mismatches    = 0;
         events_seen   = 0;
         max_reports   = 60;
      endfunction

      function void set_register(logic [REG_INDEX_WIDTH-1:0] index,
                                 logic [REG_WIDTH-1:0] value);
         case (index)
            REG_EXPECTED_VERSION: version_code = value;
            REG_TEMPLATE_CODE:    template_code = value;
            REG_OPTIONS_CODE:     options_code = value;
            default: ;
         endcase
      endfunction

      function void push_error(error_type code);
         rsp_payload_type ev;
         ev = '0;
         ev.event_res = EV_ERR;
         ev.error_code = code;
         halted = 1'b1;
         pending_events.push_back(ev);
      endfunction

      // Pick what follows a finished header or set; report end of message.
      function bit close_unit();
         if (msg_left == 0) begin
            phase = PH_HEADER;
            hdr_count = 0;
            return 1'b1;
         end
         if (msg_left >= SET_HDR_BYTES) begin
            phase = PH_SETHDR;
            sethdr_count = 0;
         end else begin
            phase = PH_SKIP;
         end
         return 1'b0;
      endfunction

      function void take_stream_item(logic [BYTE_WIDTH-1:0] b, logic stream_end);
         rsp_payload_type      ev;
         logic [LEN_WIDTH-1:0] msg_len;
         logic [LEN_WIDTH-1:0] set_len;
         logic [LEN_WIDTH-1:0] set_body;
         if (halted) return;
         ev = '0;
         if (stream_end) begin
            if (phase == PH_HEADER && hdr_count == 0) begin
               halted = 1'b1;
               ev.event_res = EV_END;
               pending_events.push_back(ev);
            end else if (phase == PH_HEADER) begin
               push_error(ERR_SHORT_HEADER);
            end else begin
               push_error(ERR_SHORT_BODY);
            end
            return;
         end
         case (phase)
            PH_HEADER: begin
               hdr_bytes = {hdr_bytes[119:0], b};
               hdr_count++;
               if (hdr_count < HEADER_BYTES) return;
               hdr_count = 0;
               msg_len = hdr_bytes[111:96];
               if (hdr_bytes[127:112] != version_code) begin
                  push_error(ERR_BAD_VERSION);
                  return;
               end
               if (msg_len < HEADER_BYTES) begin
                  push_error(ERR_BAD_LENGTH);
                  return;
               end
               ev.event_res = EV_MSG;
               ev.length_field = msg_len;
               ev.export_time = hdr_bytes[95:64];
               ev.sequence_number = hdr_bytes[63:32];
               ev.domain_id = hdr_bytes[31:0];
               msg_left = msg_len - HEADER_BYTES;
               ev.last_in_message = close_unit();
            end
            PH_SETHDR: begin
               sethdr_bytes = {sethdr_bytes[23:0], b};
               sethdr_count = (sethdr_count + 1) % SET_HDR_BYTES;
               msg_left--;
               if (sethdr_count != 0) return;
               set_len = sethdr_bytes[15:0];
               if (set_len < SET_HDR_BYTES) begin
                  push_error(ERR_BAD_LENGTH);
                  return;
               end
               set_body = set_len - SET_HDR_BYTES;
               if (set_body > msg_left) begin
                  push_error(ERR_LONG_SET);
                  return;
               end
               if (sethdr_bytes[31:16] == template_code) cur_class = CLASS_TEMPLATE;
               else if (sethdr_bytes[31:16] == options_code) cur_class = CLASS_OPTIONS;
               else cur_class = CLASS_DATA;
               set_left = set_body;
               ev.event_res = EV_SETHDR;
               ev.set_identifier = sethdr_bytes[31:16];
               ev.set_class = cur_class;
               ev.length_field = set_body;
               if (set_body == 0) begin
                  ev.last_in_set = 1'b1;
                  ev.last_in_message = close_unit();
               end else begin
                  phase = PH_BODY;
               end
            end
            PH_BODY: begin
               ev.event_res = EV_BYTE;
               ev.body_byte = b;
               ev.set_identifier = sethdr_bytes[31:16];
               ev.set_class = cur_class;
               set_left--;
               msg_left--;
               if (set_left == 0) begin
                  ev.last_in_set = 1'b1;
                  ev.last_in_message = close_unit();
               end
            end
            default: begin
               ev.event_res = EV_SKIP;
               ev.body_byte = b;
               msg_left--;
               if (msg_left == 0) begin
                  phase = PH_HEADER;
                  hdr_count = 0;
                  ev.last_in_message = 1'b1;
               end
            end
         endcase
         pending_events.push_back(ev);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= max_reports) $display("MISMATCH %s", msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("event %0d %s: got %0h, want %0h", events_seen, name, got, want));
      endtask

      task check_event(rsp_payload_type got);
         rsp_payload_type want;
         events_seen++;
         if (pending_events.size() == 0) begin
            report($sformatf("event %0d of kind %0d with none outstanding",
                             events_seen, got.event_res));
            return;
         end
         want = pending_events.pop_front();
         compare_field("event_res", got.event_res, want.event_res);
         compare_field("last_in_set", got.last_in_set, want.last_in_set);
         compare_field("last_in_message", got.last_in_message, want.last_in_message);
         compare_field("body_byte", got.body_byte, want.body_byte);
         compare_field("set_identifier", got.set_identifier, want.set_identifier);
         compare_field("set_class", got.set_class, want.set_class);
         compare_field("length_field", got.length_field, want.length_field);
         compare_field("export_time", got.export_time, want.export_time);
         compare_field("sequence_number", got.sequence_number, want.sequence_number);
         compare_field("domain_id", got.domain_id, want.domain_id);
         compare_field("error_code", got.error_code, want.error_code);
      endtask
   endclass

endpackage

/* bench/ipfix_message_deframer_top_tb.sv */
// Self-checking bench for the IPFIX message deframer: random framed streams, backpressure, CSRs.
module ipfix_message_deframer_top_tb;
   import imd_pkg::*;
   import imd_bench_pkg::*;

   localparam int unsigned RANDOM_ITEMS    = 850;
   localparam int unsigned PHASES          = 5;
   localparam int unsigned HOLD_OFF_CYCLES = 80;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned TAIL_CYCLES     = 16;
   localparam int unsigned IDLE_LIMIT      = 1000;
   localparam logic [REG_INDEX_WIDTH-1:0] UNUSED_REG_INDEX = 2'd3;

   typedef enum int unsigned {
      END_CLEAN,
      END_SHORT_HEADER,
      END_BAD_VERSION,
      END_BAD_BOTH,
      END_BAD_MSG_LEN,
      END_SHORT_BODY,
      END_BAD_SET_LEN,
      END_LONG_SET
   } closing_kind_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [REG_INDEX_WIDTH-1:0] csr_index;
   logic [REG_WIDTH-1:0]       csr_write_data;

   imd_req_if req_if ();
   imd_rsp_if rsp_if ();

   deframer_scoreboard    sb;
   logic [BYTE_WIDTH-1:0] frame[$];
   bit                    sender_idles;
   int unsigned           hold_off_req;
   int unsigned           items_sent;
   int unsigned           idle_cycles;

   ipfix_message_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no transfer for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void put16(logic [15:0] v);
      frame.push_back(v[15:8]);
      frame.push_back(v[7:0]);
   endfunction

   function automatic void put32(logic [31:0] v);
      put16(v[31:16]);
      put16(v[15:0]);
   endfunction

   function automatic void put_header(logic [15:0] ver, logic [15:0] len,
                                      logic [31:0] stamp, logic [31:0] seq,
                                      logic [31:0] domain);
      put16(ver);
      put16(len);
      put32(stamp);
      put32(seq);
      put32(domain);
   endfunction

   function automatic logic [15:0] pick_set_id();
      case ($urandom_range(0, 6))
         0, 1:    return sb.template_code;
         2, 3:    return sb.options_code;
         4:       return 16'h0000;
         5:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void random_message();
      int unsigned n_sets;
      int unsigned skip;
      int unsigned total;
      int unsigned body_len[4];
      n_sets = $urandom_range(0, 4);
      total = HEADER_BYTES;
      for (int i = 0; i < n_sets; i++) begin
         body_len[i] = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 10);
         total += SET_HDR_BYTES + body_len[i];
      end
      skip = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      total += skip;
      put_header(sb.version_code, 16'(total), $urandom, $urandom, $urandom);
      for (int i = 0; i < n_sets; i++) begin
         put16(pick_set_id());
         put16(16'(body_len[i] + SET_HDR_BYTES));
         repeat (body_len[i]) frame.push_back(8'($urandom));
      end
      repeat (skip) frame.push_back(8'($urandom));
   endfunction

   function automatic rsp_payload_type observed_event();
      rsp_payload_type ev;
      ev.event_res       = rsp_if.event_res;
      ev.last_in_set     = rsp_if.last_in_set;
      ev.last_in_message = rsp_if.last_in_message;
      ev.body_byte       = rsp_if.body_byte;
      ev.set_identifier  = rsp_if.set_identifier;
      ev.set_class       = rsp_if.set_class;
      ev.length_field    = rsp_if.length_field;
      ev.export_time     = rsp_if.export_time;
      ev.sequence_number = rsp_if.sequence_number;
      ev.domain_id       = rsp_if.domain_id;
      ev.error_code      = rsp_if.error_code;
      return ev;
   endfunction

   task automatic send_item(logic [BYTE_WIDTH-1:0] b, logic stream_end);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.stream_end <= stream_end;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.take_stream_item(b, stream_end);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_item(frame[i], 1'b0);
      frame.delete();
   endtask

   // Hold the input until every outstanding event has been taken.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [REG_INDEX_WIDTH-1:0] index, logic [REG_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   task automatic send_closing(closing_kind_type kind);
      logic [15:0] ver;
      int unsigned keep;
      int unsigned body;
      ver = sb.version_code;
      body = $urandom_range(0, 8);
      case (kind)
         END_SHORT_HEADER: repeat ($urandom_range(1, 15)) frame.push_back(8'($urandom));
         END_BAD_VERSION:
            put_header(ver ^ (16'd1 << $urandom_range(0, 15)), 16'($urandom_range(16, 65535)),
                       $urandom, $urandom, $urandom);
         END_BAD_BOTH:
            put_header(ver ^ (16'd1 << $urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                       $urandom, $urandom, $urandom);
         END_BAD_MSG_LEN:
            put_header(ver, 16'($urandom_range(0, 15)), $urandom, $urandom, $urandom);
         END_SHORT_BODY: begin
            do begin
               frame.delete();
               random_message();
            end while (frame.size() <= HEADER_BYTES);
            keep = $urandom_range(HEADER_BYTES, frame.size() - 1);
            while (frame.size() > keep) void'(frame.pop_back());
         end
         END_BAD_SET_LEN: begin
            put_header(ver, 16'(HEADER_BYTES + SET_HDR_BYTES + body), $urandom, $urandom,
                       $urandom);
            put16(pick_set_id());
            put16(16'($urandom_range(0, 3)));
         end
         END_LONG_SET: begin
            put_header(ver, 16'(HEADER_BYTES + SET_HDR_BYTES + body), $urandom, $urandom,
                       $urandom);
            put16(pick_set_id());
            put16(16'(SET_HDR_BYTES + body + $urandom_range(1, 200)));
         end
         default: ;
      endcase
      send_frame();
      send_item(8'($urandom), 1'b1);
   endtask

   initial begin : event_sink
      int unsigned stall;
      int unsigned taken;
      int unsigned holds_done;
      bit          idles;
      rsp_if.ready = 1'b0;
      taken = 0;
      holds_done = 0;
      idles = 1'b1;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken % 16 == 0) idles = ($urandom_range(0, 2) != 0);
         stall = idles ? $urandom_range(0, 11) : 0;
         if (hold_off_req != holds_done) begin
            stall = HOLD_OFF_CYCLES;
            holds_done = hold_off_req;
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         sb.check_event(observed_event());
         taken++;
      end
   end

   initial begin : stimulus
      int unsigned      phase_target;
      closing_kind_type closing;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.stream_end = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      hold_off_req = 0;
      sender_idles = 1'b1;
      items_sent = 0;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty message, then template, options and data sets and a skipped byte
      put_header(EXPECTED_VERSION_RESET, 16'd16, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      put_header(EXPECTED_VERSION_RESET, 16'd31, 32'h0, 32'hFFFF_FFFF, 32'h0);
      put16(TEMPLATE_CODE_RESET);
      put16(16'd4);
      put16(OPTIONS_CODE_RESET);
      put16(16'd5);
      frame.push_back(8'hFF);
      put16(16'hFFFF);
      put16(16'd5);
      frame.push_back(8'h00);
      frame.push_back(8'hA5);
      send_frame();

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: begin
               write_reg(REG_EXPECTED_VERSION, 16'h0000);
               write_reg(REG_TEMPLATE_CODE, 16'h0000);
               write_reg(REG_OPTIONS_CODE, 16'h0000);
               write_reg(UNUSED_REG_INDEX, 16'($urandom));
            end
            1: begin
               write_reg(REG_EXPECTED_VERSION, 16'hFFFF);
               write_reg(REG_TEMPLATE_CODE, 16'h0000);
               write_reg(REG_OPTIONS_CODE, 16'hFFFF);
            end
            3: begin
               write_reg(REG_EXPECTED_VERSION, EXPECTED_VERSION_RESET);
               write_reg(REG_TEMPLATE_CODE, TEMPLATE_CODE_RESET);
               write_reg(REG_OPTIONS_CODE, OPTIONS_CODE_RESET);
            end
            default: begin
               write_reg(REG_EXPECTED_VERSION, 16'($urandom));
               write_reg(REG_TEMPLATE_CODE, 16'($urandom));
               write_reg(REG_OPTIONS_CODE, 16'($urandom));
               write_reg(UNUSED_REG_INDEX, 16'($urandom));
            end
         endcase
         csr_write_enable <= 1'b0;
         if (p == 1 || p == 3) hold_off_req++;
         phase_target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_target) begin
            sender_idles = ($urandom_range(0, 2) != 0);
            random_message();
            send_frame();
         end
      end

      // Finish the stream with one terminating case, then feed bytes the block must drop.
      drain();
      closing = closing_kind_type'($urandom_range(END_CLEAN, END_LONG_SET));
      send_closing(closing);
      repeat (6) send_item(8'($urandom), 1'($urandom_range(0, 1)));

      req_if.valid <= 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
